// ----- sv/epaper_pixel_drive_engine_assert.svh -----
// Assertion macros used by the checker file of the pixel drive engine.
`ifndef EPAPER_PIXEL_DRIVE_ENGINE_ASSERT_SVH
`define EPAPER_PIXEL_DRIVE_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EPDE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EPDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/epde_pkg.sv -----
// Shared constants, drive codes and payload types of the pixel drive engine.
package epde_pkg;

	localparam int ROWS      = 512;
	localparam int ROW_BYTES = 128;
	localparam int DEPTH     = ROWS * ROW_BYTES;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int PIX_N     = 8;
	localparam int NIB_W     = 4;
	localparam int WORD_W    = PIX_N * NIB_W;
	localparam int CNT_W     = 3;
	localparam int DONE_BIT  = 2;
	localparam int DRIVE_W   = 2 * PIX_N;

	localparam logic [CNT_W-1:0] PASSES_RESET = 3'd3;

	// Per-pixel drive codes
	localparam logic [1:0] DRV_NONE = 2'b00;
	localparam logic [1:0] DRV_ONE  = 2'b01;
	localparam logic [1:0] DRV_ZERO = 2'b10;

	typedef struct packed {
		logic [8:0] row_index;
		logic [6:0] column_byte;
		logic [7:0] pixel_byte;
		logic       last_in_row;
	} src_item_t;

	typedef struct packed {
		logic [7:0] drive_first_byte;
		logic [7:0] drive_second_byte;
		logic       row_needs_more;
		logic       row_done_marker;
	} drv_item_t;

	// Write request into the pixel state memory
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} ram_wr_t;

	function automatic logic in_frame(input logic [8:0] row, input logic [6:0] col);
		return (int'(row) < ROWS) && (int'(col) < ROW_BYTES);
	endfunction

	function automatic logic [ADDR_W-1:0] frame_addr(input logic [8:0] row,
		input logic [6:0] col);
		return ADDR_W'(int'(row) * ROW_BYTES + int'(col));
	endfunction

endpackage

// ----- sv/epaper_pixel_drive_engine.sv -----
// Top level: read-modify-write pipeline over the pixel state memory.
//
//  channel   | signals                      | moves
//  ----------+------------------------------+-----------------------------
//  src       | src_valid src_stall src_item | one source byte per transfer
//  drv       | drv_valid drv_stall drv_item | two drive bytes + row flags
//  cfg       | cfg_we cfg_wdata             | drive_passes write
//
// One item per clock while drv is unstalled and the sweep is done; an accepted
// item passes the update stage register, then the drv output register. The rate
// is set by the single state memory: read at accept, update and write back as
// the item leaves the update stage, with the last write-back forwarded to a
// following item at the same address. After reset a clearing sweep zeroes all
// 65536 entries; src_stall stays high until it ends. Config writes are taken
// throughout. drv has an output register: while a result waits, one more src
// transfer is taken into the update stage, then src_stall follows drv_stall.
module epaper_pixel_drive_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_stall,
	input  epde_pkg::src_item_t           src_item,
	output logic                          drv_valid,
	input  logic                          drv_stall,
	output epde_pkg::drv_item_t           drv_item,
	input  logic                          cfg_we,
	input  logic [epde_pkg::CNT_W-1:0]    cfg_wdata
);
	import epde_pkg::*;

	logic              busy;
	logic              src_fire;
	logic              adv;
	logic [ADDR_W-1:0] src_addr;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] cur_word;
	logic [WORD_W-1:0] next_word;
	logic [DRIVE_W-1:0] drive;
	logic              pending;
	logic              pend_all;
	ram_wr_t           wr;

	logic              valid_s1;
	src_item_t         item_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              frame_s1;
	logic              hit_s1;

	logic [WORD_W-1:0] fwd_q;
	logic [CNT_W-1:0]  passes_q;
	logic              acc_q;
	logic              drv_valid_q;
	drv_item_t         drv_item_q;

	assign src_addr  = frame_addr(src_item.row_index, src_item.column_byte);
	assign adv       = valid_s1 && (!drv_valid_q || !drv_stall);
	assign src_stall = busy || (valid_s1 && !adv);
	assign src_fire  = src_valid && !src_stall;

	assign wr.en   = adv && frame_s1;
	assign wr.addr = addr_s1;
	assign wr.data = next_word;

	epde_state_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (src_fire),
		.rd_addr (src_addr),
		.rd_data (rd_data),
		.wr      (wr),
		.busy    (busy)
	);

	// Take the previous write-back when it hit the same entry
	assign cur_word = hit_s1 ? fwd_q : rd_data;

	epde_pixel_update u_upd (
		.word      (cur_word),
		.pixels    (item_s1.pixel_byte),
		.passes    (passes_q),
		.next_word (next_word),
		.drive     (drive),
		.pending   (pending)
	);

	assign pend_all = acc_q | (frame_s1 & pending);

	// Hold the drive_passes register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passes_q <= PASSES_RESET;
		end else if (cfg_we) begin
			passes_q <= cfg_wdata;
		end
	end

	// Advance the update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
			acc_q    <= 1'b0;
		end else begin
			if (src_fire) begin
				valid_s1 <= 1'b1;
				hit_s1   <= wr.en && (src_addr == addr_s1);
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				acc_q <= item_s1.last_in_row ? 1'b0 : pend_all;
			end
		end
	end

	// Stage payload and forwarded word
	always_ff @(posedge clk) begin
		if (src_fire) begin
			item_s1  <= src_item;
			addr_s1  <= src_addr;
			frame_s1 <= in_frame(src_item.row_index, src_item.column_byte);
		end
		if (wr.en) begin
			fwd_q <= next_word;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid_q <= 1'b0;
		end else if (adv) begin
			drv_valid_q <= 1'b1;
		end else if (!drv_stall) begin
			drv_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drv_item_q.drive_first_byte  <= frame_s1 ? drive[15:8] : 8'h00;
			drv_item_q.drive_second_byte <= frame_s1 ? drive[7:0] : 8'h00;
			drv_item_q.row_needs_more    <= item_s1.last_in_row & pend_all;
			drv_item_q.row_done_marker   <= item_s1.last_in_row;
		end
	end

	assign drv_valid = drv_valid_q;
	assign drv_item  = drv_item_q;

endmodule

// ----- sv/epde_state_ram.sv -----
// Pixel state memory with registered read and post-reset clearing sweep.
module epde_state_ram (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [epde_pkg::ADDR_W-1:0]     rd_addr,
	output logic [epde_pkg::WORD_W-1:0]     rd_data,
	input  epde_pkg::ram_wr_t               wr,
	output logic                            busy
);
	import epde_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              busy_q;

	// Walk every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			sweep_q <= '0;
		end else if (busy_q) begin
			sweep_q <= sweep_q + 1'b1;
			if (sweep_q == ADDR_W'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Clear or write back, and register the read
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[sweep_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign busy    = busy_q;

endmodule

// ----- sv/epde_pixel_update.sv -----
// Per-pixel target compare, pulse counting and drive code packing for one byte.
module epde_pixel_update (
	input  logic [epde_pkg::WORD_W-1:0]  word,
	input  logic [epde_pkg::PIX_N-1:0]   pixels,
	input  logic [epde_pkg::CNT_W-1:0]   passes,
	output logic [epde_pkg::WORD_W-1:0]  next_word,
	output logic [epde_pkg::DRIVE_W-1:0] drive,
	output logic                         pending
);
	import epde_pkg::*;

	// Update each pixel's nibble independently
	always_comb begin
		logic [NIB_W-1:0] nib;
		logic             tgt;
		logic [CNT_W-1:0] cnt;
		logic [1:0]       code;
		next_word = '0;
		drive     = '0;
		pending   = 1'b0;
		for (int p = 0; p < PIX_N; p++) begin
			nib = word[NIB_W*p +: NIB_W];
			tgt = pixels[PIX_N-1-p];
			// restart the count when the target flips
			cnt = (nib[NIB_W-1] != tgt) ? '0 : nib[CNT_W-1:0];
			if (cnt[DONE_BIT]) begin
				code = DRV_NONE;
			end else begin
				code = tgt ? DRV_ONE : DRV_ZERO;
				cnt  = cnt + 1'b1;
			end
			if (cnt >= passes) begin
				cnt[DONE_BIT] = 1'b1;
			end
			if (!cnt[DONE_BIT]) begin
				pending = 1'b1;
			end
			drive[2*(PIX_N-1-p) +: 2]  = code;
			next_word[NIB_W*p +: NIB_W] = {tgt, cnt};
		end
	end

endmodule

// ----- sv/epde_checker.sv -----
// Port-level checks of the pixel drive engine, bound to the top level.
`include "epaper_pixel_drive_engine_assert.svh"

module epde_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          src_valid,
	input logic                          src_stall,
	input epde_pkg::src_item_t           src_item,
	input logic                          drv_valid,
	input logic                          drv_stall,
	input epde_pkg::drv_item_t           drv_item
);
	import epde_pkg::*;

	logic [7:0] bad_first;
	logic [7:0] bad_second;
	logic       src_take;
	logic       drv_wait;

	// A code of 11 in any pixel slot is illegal
	assign bad_first  = drv_item.drive_first_byte & (drv_item.drive_first_byte >> 1) & 8'h55;
	assign bad_second = drv_item.drive_second_byte & (drv_item.drive_second_byte >> 1) & 8'h55;

	assign src_take = src_valid && !src_stall;
	assign drv_wait = drv_valid && drv_stall;

	`EPDE_ASSERT_NOW(a_flag_on_last, drv_valid && drv_item.row_needs_more, drv_item.row_done_marker, "row flag off last byte")
	`EPDE_ASSERT_NOW(a_no_code_11, drv_valid, (bad_first == 8'h00) && (bad_second == 8'h00), "illegal drive code")
	`EPDE_ASSERT_NOW(a_full_stalls, $past(src_take) && $past(drv_wait) && drv_wait, src_stall, "transfer taken while full")
	`EPDE_ASSERT_NEXT(a_drv_hold, drv_wait, drv_valid && $stable(drv_item), "stalled result changed")
	`EPDE_ASSERT_NEXT(a_src_hold, src_valid && src_stall, src_valid && $stable(src_item), "stalled source changed")

endmodule

bind epaper_pixel_drive_engine epde_checker u_epde_checker (.*);

// ----- test/epaper_pixel_drive_engine_test.sv -----
// Self-checking testbench for the e-paper pixel drive engine.
module epaper_pixel_drive_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import epde_pkg::*;

	localparam int PHASE_ITEMS = 210;
	localparam int LONG_HOLD   = 300;
	localparam logic [CNT_W-1:0] PASS_PLAN [8] = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd5, 3'd6,
		3'd3};

	// Mirror of the per-pixel state and the expected drive transfers
	class pixel_drive_tracker;
		bit [WORD_W-1:0] state_mem [DEPTH];
		bit              row_pending;
		bit [CNT_W-1:0]  passes;
		drv_item_t       pending_drive [$];
		int              errors;
		int              checked;
		int              rows_pending;
		int              rows_settled;

		function new();
			passes = PASSES_RESET;
		endfunction

		function int outstanding();
			return pending_drive.size();
		endfunction

		// Update the pixel counters for one source byte and queue its drive bytes
		function void note_source(src_item_t s);
			bit [WORD_W-1:0] word;
			bit [WORD_W-1:0] next_word;
			bit [DRIVE_W-1:0] drive;
			bit [CNT_W-1:0] cnt;
			bit [1:0] code;
			bit tgt;
			bit busy;
			int addr;
			drv_item_t want;
			drive = '0;
			busy = 1'b0;
			if (int'(s.row_index) < ROWS && int'(s.column_byte) < ROW_BYTES) begin
				addr = int'(s.row_index) * ROW_BYTES + int'(s.column_byte);
				word = state_mem[addr];
				next_word = '0;
				for (int p = 0; p < PIX_N; p++) begin
					tgt = s.pixel_byte[PIX_N-1-p];
					cnt = word[NIB_W*p +: CNT_W];
					// restart the pulse count when the target flips
					if (word[NIB_W*p + CNT_W] != tgt)
						cnt = '0;
					if (cnt[DONE_BIT]) begin
						code = DRV_NONE;
					end else begin
						code = tgt ? DRV_ONE : DRV_ZERO;
						cnt = cnt + 1'b1;
					end
					if (cnt >= passes)
						cnt[DONE_BIT] = 1'b1;
					if (!cnt[DONE_BIT])
						busy = 1'b1;
					drive[DRIVE_W-1-2*p -: 2] = code;
					next_word[NIB_W*p +: NIB_W] = {tgt, cnt};
				end
				state_mem[addr] = next_word;
				row_pending |= busy;
			end
			want.drive_first_byte  = drive[15:8];
			want.drive_second_byte = drive[7:0];
			want.row_done_marker   = s.last_in_row;
			want.row_needs_more    = 1'b0;
			if (s.last_in_row) begin
				want.row_needs_more = row_pending;
				if (row_pending)
					rows_pending++;
				else
					rows_settled++;
				row_pending = 1'b0;
			end
			pending_drive.push_back(want);
		endfunction

		// Compare one drive transfer with the oldest expectation
		function void check_drive(drv_item_t got);
			drv_item_t want;
			if (pending_drive.size() == 0) begin
				$display("%0t: drive transfer with none expected, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_drive.pop_front();
			checked++;
			if (got.drive_first_byte !== want.drive_first_byte) begin
				$display("%0t: drive_first_byte expected %02h actual %02h", $time,
					want.drive_first_byte, got.drive_first_byte);
				errors++;
			end
			if (got.drive_second_byte !== want.drive_second_byte) begin
				$display("%0t: drive_second_byte expected %02h actual %02h", $time,
					want.drive_second_byte, got.drive_second_byte);
				errors++;
			end
			if (got.row_needs_more !== want.row_needs_more) begin
				$display("%0t: row_needs_more expected %b actual %b", $time,
					want.row_needs_more, got.row_needs_more);
				errors++;
			end
			if (got.row_done_marker !== want.row_done_marker) begin
				$display("%0t: row_done_marker expected %b actual %b", $time,
					want.row_done_marker, got.row_done_marker);
				errors++;
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            src_valid;
	logic            src_stall;
	src_item_t       src_item;
	logic            drv_valid;
	logic            drv_stall;
	drv_item_t       drv_item;
	logic            cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	pixel_drive_tracker tracker = new();
	logic [7:0] shown_pixels [int];
	int burst_left = 0;
	int sent = 0;

	epaper_pixel_drive_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.drv_valid (drv_valid),
		.drv_stall (drv_stall),
		.drv_item  (drv_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every drive transfer
	always @(posedge clk) begin
		if (arst_n === 1'b1 && drv_valid === 1'b1 && drv_stall === 1'b0)
			tracker.check_drive(drv_item);
	end

	// Offer one source byte; bursts of random length separated by random gaps
	task automatic send_source(input src_item_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		src_valid <= 1'b1;
		src_item <= item;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		tracker.note_source(item);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [8:0] row, input logic [6:0] col,
		input logic [7:0] pix, input logic last);
		send_source('{row_index: row, column_byte: col, pixel_byte: pix, last_in_row: last});
	endtask

	// Drop valid and hold until every queued drive transfer has arrived
	task automatic wait_drained();
		src_valid <= 1'b0;
		burst_left = 0;
		while (tracker.outstanding() != 0) @(negedge clk);
	endtask

	task automatic write_passes(input logic [CNT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.passes = value;
	endtask

	// Mostly repeat the previous target so counters run to done
	function automatic logic [7:0] next_pixels(input int addr);
		logic [7:0] prev;
		prev = shown_pixels.exists(addr) ? shown_pixels[addr] : 8'h00;
		case ($urandom_range(0, 5))
			3: return prev ^ (8'h01 << $urandom_range(0, 7));
			4: return 8'($urandom_range(0, 255));
			5: return ~prev;
			default: return prev;
		endcase
	endfunction

	// Scan part or all of one row, usually closed by a last_in_row byte
	task automatic feed_row(input logic [8:0] row);
		int nbytes;
		int first;
		int addr;
		bit broken;
		src_item_t item;
		nbytes = ($urandom_range(0, 15) == 0) ? $urandom_range(9, ROW_BYTES) : $urandom_range(1, 8);
		first = ($urandom_range(0, 3) == 0) ? ROW_BYTES - nbytes : 0;
		broken = ($urandom_range(0, 9) == 0);
		for (int c = 0; c < nbytes; c++) begin
			addr = int'(row) * ROW_BYTES + first + c;
			item.row_index = row;
			item.column_byte = 7'(first + c);
			item.pixel_byte = next_pixels(addr);
			item.last_in_row = (c == nbytes - 1) && !broken;
			shown_pixels[addr] = item.pixel_byte;
			send_source(item);
		end
	endtask

	// Receiver: change the stall pattern every so often, with two long hold-offs
	initial begin
		int mode;
		int span;
		int holds;
		int beat;
		drv_stall = 1'b0;
		holds = 0;
		beat = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 150);
			repeat (span) begin
				@(negedge clk);
				beat++;
				if (holds < 2 && tracker.checked >= 400 + 600 * holds && src_valid === 1'b1) begin
					drv_stall <= 1'b1;
					repeat (LONG_HOLD) @(negedge clk);
					holds++;
				end
				case (mode)
					0: drv_stall <= 1'b0;
					1: drv_stall <= ($urandom_range(0, 3) == 0);
					2: drv_stall <= ($urandom_range(0, 3) != 0);
					default: drv_stall <= (beat % 5) < 2;
				endcase
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [8:0] row_pool [4];
		int phase_start;
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed bytes under the reset pass count
		send_fields(9'd0, 7'd0, 8'h00, 1'b1);
		send_fields(9'd0, 7'd0, 8'hFF, 1'b1);
		send_fields(9'd0, 7'd0, 8'hFF, 1'b0);
		send_fields(9'd0, 7'd0, 8'hFF, 1'b0);
		send_fields(9'd0, 7'd0, 8'hFF, 1'b1);
		send_fields(9'd0, 7'd0, 8'hFF, 1'b1);
		send_fields(9'd511, 7'd127, 8'hA5, 1'b0);
		send_fields(9'd511, 7'd127, 8'hA5, 1'b1);
		send_fields(9'd511, 7'd126, 8'h0F, 1'b0);
		send_fields(9'd511, 7'd126, 8'hF0, 1'b1);
		send_fields(9'd256, 7'd64, 8'h80, 1'b0);
		send_fields(9'd256, 7'd64, 8'h01, 1'b1);
		send_fields(9'd170, 7'd85, 8'h5A, 1'b1);
		send_fields(9'd341, 7'd42, 8'hC3, 1'b1);
		send_fields(9'd0, 7'd0, 8'h7E, 1'b0);
		send_fields(9'd0, 7'd0, 8'h81, 1'b1);
		wait_drained();

		// Random phases, one pass count each
		for (int ph = 0; ph < 8; ph++) begin
			write_passes(PASS_PLAN[ph]);
			row_pool[0] = 9'd0;
			row_pool[1] = 9'd511;
			row_pool[2] = 9'($urandom_range(0, ROWS - 1));
			row_pool[3] = 9'($urandom_range(0, ROWS - 1));
			phase_start = sent;
			while (sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					send_fields(9'($urandom_range(0, 511)), 7'($urandom_range(0, 127)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				else
					feed_row(row_pool[$urandom_range(0, 3)]);
			end
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (tracker.outstanding() != 0) begin
			$display("%0t: %0d drive transfers never arrived", $time, tracker.outstanding());
			tracker.errors++;
		end
		$display("Sent %0d source bytes over pass counts 0..7; checked %0d drive transfers.",
			sent, tracker.checked);
		$display("Row ends seen: %0d still pending, %0d settled.", tracker.rows_pending,
			tracker.rows_settled);
		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: clearing sweep plus a wide margin for stalls and gaps
	initial begin
		#5ms;
		$display("Timeout at %0t", $time);
		$display("Mismatches found");
		$finish;
	end

endmodule
